FILE: src/assert_macros.svh
// Assertion macros shared by the modules of the scan response matcher.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_PROP(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error("assertion failed");
`define ASSERT_NEVER(lbl, clk, rst_n, expr) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
		else $error("forbidden condition seen");
`else
`define ASSERT_PROP(lbl, clk, rst_n, prop)
`define ASSERT_NEVER(lbl, clk, rst_n, expr)
`endif
`endif

FILE: src/tsrm_pkg.sv
// Types, constants and command structs of the scan response matcher.
package tsrm_pkg;

	localparam int unsigned ENTRIES_DEF = 16;
	localparam int unsigned TCP_HDR_BYTES = 20;

	localparam logic [7:0] IP_PROTO_TCP = 8'd6;
	localparam logic [7:0] FLAG_SYN_ACK = 8'h12;
	localparam logic [7:0] FLAG_RST = 8'h04;
	localparam logic [5:0] IP_HDR_MIN = 6'd20;
	localparam logic [5:0] IP_HDR_MAX = 6'd60;
	localparam logic [4:0] CNT_MAX = 5'd31;

	typedef enum logic [1:0] {
		OP_REGISTER = 2'd0,
		OP_UNREGISTER = 2'd1,
		OP_PACKET = 2'd2,
		OP_READ = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ST_PENDING = 2'd0,
		ST_CLOSED = 2'd1,
		ST_OPEN = 2'd2
	} st_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_HOLD,
		S_READ_WAIT,
		S_WALK
	} state_t;

	typedef struct packed {
		logic [31:0] addr;
		logic [15:0] peer_port;
		logic [15:0] local_port;
		logic syn;
		st_t result;
		logic [31:0] saved_ack;
	} entry_t;

	typedef struct packed {
		op_t operation;
		logic [3:0] slot;
		logic [31:0] peer_addr;
		logic [15:0] peer_port;
		logic [15:0] local_port;
		logic syn_mode;
		logic [7:0] ip_proto;
		logic [3:0] ihl_words;
		logic [10:0] captured_len;
		logic [7:0] tcp_flag_bits;
		logic [31:0] ack_number;
	} req_word_t;

	typedef struct packed {
		logic [1:0] entry_status;
		logic [31:0] entry_ack;
		logic [4:0] match_count;
		logic header_ok;
	} rsp_word_t;

	typedef struct packed {
		logic fire;
		logic walk_issue;
		logic ld_zero;
		logic ld_read;
		logic ld_walk;
	} ctrl_cmd_t;

	typedef struct packed {
		op_t op;
		logic hdr_pass;
		logic issue_done;
		logic pipe_empty;
	} ctrl_sts_t;

endpackage

FILE: src/tsrm_req_if.sv
// Request channel carrying one operation word into the matcher.
interface tsrm_req_if;
	import tsrm_pkg::*;

	logic valid;
	logic ready;
	op_t operation;
	logic [3:0] slot;
	logic [31:0] peer_addr;
	logic [15:0] peer_port;
	logic [15:0] local_port;
	logic syn_mode;
	logic [7:0] ip_proto;
	logic [3:0] ihl_words;
	logic [10:0] captured_len;
	logic [7:0] tcp_flag_bits;
	logic [31:0] ack_number;

	modport source (
		output valid, operation, slot, peer_addr, peer_port, local_port, syn_mode,
		output ip_proto, ihl_words, captured_len, tcp_flag_bits, ack_number,
		input ready
	);

	modport sink (
		input valid, operation, slot, peer_addr, peer_port, local_port, syn_mode,
		input ip_proto, ihl_words, captured_len, tcp_flag_bits, ack_number,
		output ready
	);
endinterface

FILE: src/tsrm_rsp_if.sv
// Response channel carrying one result word out of the matcher.
interface tsrm_rsp_if;
	logic valid;
	logic ready;
	logic [1:0] entry_status;
	logic [31:0] entry_ack;
	logic [4:0] match_count;
	logic header_ok;

	modport source (
		output valid, entry_status, entry_ack, match_count, header_ok,
		input ready
	);

	modport sink (
		input valid, entry_status, entry_ack, match_count, header_ok,
		output ready
	);
endinterface

FILE: src/tcp_scan_response_matcher_core.sv
// Top level of the TCP scan response matcher: controller, datapath and channel wiring.
//
// The block holds ENTRIES probe expectations in a single-port-read RAM, with valid and
// written bits in flip-flops so the table reads as cleared right after reset and no
// clearing pass is needed. Register and unregister words and a packet that fails the
// protocol or length check load their result once the output register is free; a read
// also waits for its registered RAM read. A packet that passes walks the whole table
// through the RAM read port, one entry per cycle with the compare and write-back one
// stage behind, and loads its match count once drained and the output register is free.
// One word is processed at a time; a new request word is accepted as soon as the
// previous one is finished, even while its result still waits in the output register.
module tcp_scan_response_matcher_core #(
	parameter int unsigned ENTRIES = tsrm_pkg::ENTRIES_DEF
) (
	input logic clk,
	input logic arst_n,
	tsrm_req_if.sink req,
	tsrm_rsp_if.source rsp
);
	import tsrm_pkg::*;

	req_word_t req_w;
	rsp_word_t rsp_w;
	ctrl_cmd_t cmd;
	ctrl_sts_t sts;

	assign req_w.operation = req.operation;
	assign req_w.slot = req.slot;
	assign req_w.peer_addr = req.peer_addr;
	assign req_w.peer_port = req.peer_port;
	assign req_w.local_port = req.local_port;
	assign req_w.syn_mode = req.syn_mode;
	assign req_w.ip_proto = req.ip_proto;
	assign req_w.ihl_words = req.ihl_words;
	assign req_w.captured_len = req.captured_len;
	assign req_w.tcp_flag_bits = req.tcp_flag_bits;
	assign req_w.ack_number = req.ack_number;

	tsrm_ctrl u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req.valid),
		.req_ready(req.ready),
		.rsp_valid(rsp.valid),
		.rsp_ready(rsp.ready),
		.sts(sts),
		.cmd(cmd)
	);

	tsrm_datapath #(
		.ENTRIES(ENTRIES)
	) u_datapath (
		.clk(clk),
		.arst_n(arst_n),
		.req_w(req_w),
		.cmd(cmd),
		.sts(sts),
		.rsp_w(rsp_w)
	);

	assign rsp.entry_status = rsp_w.entry_status;
	assign rsp.entry_ack = rsp_w.entry_ack;
	assign rsp.match_count = rsp_w.match_count;
	assign rsp.header_ok = rsp_w.header_ok;
endmodule

FILE: src/tsrm_ram.sv
// Generic single write port RAM with one registered read port.
module tsrm_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 16,
	localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input logic clk,
	input logic we,
	input logic [AW-1:0] waddr,
	input logic [WIDTH-1:0] wdata,
	input logic re,
	input logic [AW-1:0] raddr,
	output logic [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end
endmodule

FILE: src/tsrm_datapath.sv
// Entry table, header check, table walk and result register of the matcher.
`include "assert_macros.svh"

module tsrm_datapath #(
	parameter int unsigned ENTRIES = tsrm_pkg::ENTRIES_DEF
) (
	input logic clk,
	input logic arst_n,
	input tsrm_pkg::req_word_t req_w,
	input tsrm_pkg::ctrl_cmd_t cmd,
	output tsrm_pkg::ctrl_sts_t sts,
	output tsrm_pkg::rsp_word_t rsp_w
);
	import tsrm_pkg::*;

	localparam int unsigned AW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int unsigned CW = $clog2(ENTRIES + 1);
	localparam int unsigned SXW = AW + 5;

	logic [ENTRIES-1:0] valid_q;
	logic [ENTRIES-1:0] written_q;
	logic [CW-1:0] issue_cnt_q;
	logic cmp_vld_s1;
	logic [AW-1:0] cmp_idx_s1;
	logic rd_ok_s1;
	logic [4:0] match_cnt_q;
	logic [31:0] pkt_addr_q;
	logic [15:0] pkt_pport_q;
	logic [15:0] pkt_lport_q;
	logic [7:0] pkt_flags_q;
	logic [31:0] pkt_ack_q;
	rsp_word_t rsp_q;

	logic [SXW-1:0] slot_x;
	logic in_table;
	logic [AW-1:0] slot_idx;
	logic [AW-1:0] issue_idx;
	logic [5:0] hdr_bytes;
	logic is_reg;
	logic is_unreg;
	logic is_read;
	logic is_pkt;
	logic hit;
	entry_t rd_entry;
	entry_t reg_entry;
	entry_t upd_entry;
	logic ram_we;
	logic [AW-1:0] ram_waddr;
	entry_t ram_wdata;
	logic ram_re;
	logic [AW-1:0] ram_raddr;

	assign slot_x = SXW'(req_w.slot);
	assign in_table = slot_x < SXW'(ENTRIES);
	assign slot_idx = slot_x[AW-1:0];
	assign issue_idx = issue_cnt_q[AW-1:0];

	assign is_reg = cmd.fire && (req_w.operation == OP_REGISTER) && in_table;
	assign is_unreg = cmd.fire && (req_w.operation == OP_UNREGISTER) && in_table;
	assign is_read = cmd.fire && (req_w.operation == OP_READ) && in_table;
	assign is_pkt = cmd.fire && (req_w.operation == OP_PACKET);

	assign hdr_bytes = {req_w.ihl_words, 2'b00};

	assign sts.op = req_w.operation;
	assign sts.hdr_pass = (req_w.ip_proto == IP_PROTO_TCP) && (hdr_bytes >= IP_HDR_MIN) &&
		(hdr_bytes <= IP_HDR_MAX) &&
		(req_w.captured_len >= (11'(hdr_bytes) + 11'(TCP_HDR_BYTES)));
	assign sts.issue_done = (issue_cnt_q == CW'(ENTRIES));
	assign sts.pipe_empty = !cmp_vld_s1;

	assign hit = cmp_vld_s1 && valid_q[cmp_idx_s1] && (rd_entry.addr == pkt_addr_q) &&
		(rd_entry.peer_port == pkt_pport_q) && (rd_entry.local_port == pkt_lport_q);

	always_comb begin
		upd_entry = rd_entry;
		if (rd_entry.syn) begin
			if ((pkt_flags_q & FLAG_SYN_ACK) == FLAG_SYN_ACK) begin
				upd_entry.saved_ack = pkt_ack_q;
				upd_entry.result = ST_OPEN;
			end else if ((pkt_flags_q & FLAG_RST) != 8'd0) begin
				upd_entry.result = ST_CLOSED;
			end
		end else if ((pkt_flags_q & FLAG_RST) != 8'd0) begin
			upd_entry.result = ST_CLOSED;
		end
	end

	always_comb begin
		reg_entry.addr = req_w.peer_addr;
		reg_entry.peer_port = req_w.peer_port;
		reg_entry.local_port = req_w.local_port;
		reg_entry.syn = req_w.syn_mode;
		reg_entry.result = ST_PENDING;
		reg_entry.saved_ack = '0;
	end

	assign ram_we = is_reg || hit;
	assign ram_waddr = hit ? cmp_idx_s1 : slot_idx;
	assign ram_wdata = hit ? upd_entry : reg_entry;
	assign ram_re = is_read || cmd.walk_issue;
	assign ram_raddr = cmd.walk_issue ? issue_idx : slot_idx;

	tsrm_ram #(
		.WIDTH($bits(entry_t)),
		.DEPTH(ENTRIES)
	) u_table (
		.clk(clk),
		.we(ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re(ram_re),
		.raddr(ram_raddr),
		.rdata(rd_entry)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			written_q <= '0;
			issue_cnt_q <= '0;
			cmp_vld_s1 <= 1'b0;
		end else begin
			if (is_reg) begin
				valid_q[slot_idx] <= 1'b1;
				written_q[slot_idx] <= 1'b1;
			end
			if (is_unreg) begin
				valid_q[slot_idx] <= 1'b0;
			end
			if (is_pkt) begin
				issue_cnt_q <= '0;
			end else if (cmd.walk_issue) begin
				issue_cnt_q <= issue_cnt_q + CW'(1);
			end
			cmp_vld_s1 <= cmd.walk_issue;
		end
	end

	always_ff @(posedge clk) begin
		cmp_idx_s1 <= issue_idx;
		if (cmd.fire) begin
			rd_ok_s1 <= in_table && written_q[slot_idx];
		end
		if (is_pkt) begin
			pkt_addr_q <= req_w.peer_addr;
			pkt_pport_q <= req_w.peer_port;
			pkt_lport_q <= req_w.local_port;
			pkt_flags_q <= req_w.tcp_flag_bits;
			pkt_ack_q <= req_w.ack_number;
			match_cnt_q <= '0;
		end else if (hit && (match_cnt_q < CNT_MAX)) begin
			match_cnt_q <= match_cnt_q + 5'd1;
		end
		if (cmd.ld_zero) begin
			rsp_q <= '0;
		end else if (cmd.ld_read) begin
			rsp_q.entry_status <= rd_ok_s1 ? rd_entry.result : ST_PENDING;
			rsp_q.entry_ack <= rd_ok_s1 ? rd_entry.saved_ack : 32'd0;
			rsp_q.match_count <= '0;
			rsp_q.header_ok <= 1'b0;
		end else if (cmd.ld_walk) begin
			rsp_q.entry_status <= ST_PENDING;
			rsp_q.entry_ack <= '0;
			rsp_q.match_count <= match_cnt_q;
			rsp_q.header_ok <= 1'b1;
		end
	end

	assign rsp_w = rsp_q;

	`ASSERT_PROP(a_cmp_follows_issue, clk, arst_n, cmp_vld_s1 == $past(cmd.walk_issue))
	`ASSERT_PROP(a_issue_in_range, clk, arst_n, issue_cnt_q <= CW'(ENTRIES))
endmodule

FILE: src/tsrm_ctrl.sv
// Sequencing state machine of the matcher: accept, table walk and result hand-off.
`include "assert_macros.svh"

module tsrm_ctrl (
	input logic clk,
	input logic arst_n,
	input logic req_valid,
	output logic req_ready,
	output logic rsp_valid,
	input logic rsp_ready,
	input tsrm_pkg::ctrl_sts_t sts,
	output tsrm_pkg::ctrl_cmd_t cmd
);
	import tsrm_pkg::*;

	state_t state_q;
	state_t state_d;
	logic out_valid_q;
	logic free;
	logic ld_any;

	assign free = !out_valid_q || rsp_ready;
	assign ld_any = cmd.ld_zero || cmd.ld_read || cmd.ld_walk;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (ld_any) begin
				out_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		state_d = state_q;
		cmd = '0;
		req_ready = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				req_ready = 1'b1;
				if (req_valid) begin
					cmd.fire = 1'b1;
					if (sts.op == OP_READ) begin
						state_d = S_READ_WAIT;
					end else if ((sts.op == OP_PACKET) && sts.hdr_pass) begin
						state_d = S_WALK;
					end else if (free) begin
						cmd.ld_zero = 1'b1;
					end else begin
						state_d = S_HOLD;
					end
				end
			end
			S_HOLD: begin
				if (free) begin
					cmd.ld_zero = 1'b1;
					state_d = S_IDLE;
				end
			end
			S_READ_WAIT: begin
				if (free) begin
					cmd.ld_read = 1'b1;
					state_d = S_IDLE;
				end
			end
			S_WALK: begin
				cmd.walk_issue = !sts.issue_done;
				if (sts.issue_done && sts.pipe_empty && free) begin
					cmd.ld_walk = 1'b1;
					state_d = S_IDLE;
				end
			end
		endcase
	end

	assign rsp_valid = out_valid_q;

	`ASSERT_NEVER(a_no_overwrite, clk, arst_n, ld_any && out_valid_q && !rsp_ready)
	`ASSERT_PROP(a_read_done, clk, arst_n, (state_q == S_READ_WAIT && free) |=> (out_valid_q && state_q == S_IDLE))
endmodule
